/* rtl/assert_macros.svh */
// assertion helpers included by the dpr_checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* rtl/dpr_pkg.sv */
package dpr_pkg;

  localparam int unsigned MAX_DIM_DEF = 4096;

  localparam int unsigned DIM_W   = 13;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  typedef enum logic [1:0] {
    FMT_RGB555 = 2'd0,
    FMT_BGR24  = 2'd1,
    FMT_BGRX32 = 2'd2,
    FMT_NONE   = 2'd3
  } fmt_t;

  typedef enum logic [1:0] {
    REG_FORMAT = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_t;

  localparam fmt_t             FMT_RESET    = FMT_BGR24;
  localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd1;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd1;

  localparam logic [15:0] CHAN5_MASK = 16'h001f;

  typedef struct packed {
    fmt_t             fmt;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0]  pixel_x;
    logic [POS_W-1:0]  pixel_row;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              last_pixel;
  } pix_t;

endpackage

/* rtl/dpr_cfg_regs.sv */
module dpr_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dpr_pkg::PADDR_W-1:0]   paddr,
  input  logic [dpr_pkg::PDATA_W-1:0]   pwdata,
  output logic [dpr_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output dpr_pkg::cfg_t                 cfg
);

  dpr_pkg::cfg_t     cfg_r;
  dpr_pkg::cfg_t     cfg_nxt;
  logic              wr_en;
  dpr_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = dpr_pkg::reg_idx_t'(paddr[3:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        dpr_pkg::REG_FORMAT: cfg_nxt.fmt    = dpr_pkg::fmt_t'(pwdata[1:0]);
        dpr_pkg::REG_WIDTH:  cfg_nxt.width  = pwdata[dpr_pkg::DIM_W-1:0];
        dpr_pkg::REG_HEIGHT: cfg_nxt.height = pwdata[dpr_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fmt    <= dpr_pkg::FMT_RESET;
      cfg_r.width  <= dpr_pkg::WIDTH_RESET;
      cfg_r.height <= dpr_pkg::HEIGHT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      dpr_pkg::REG_FORMAT: prdata = 32'(cfg_r.fmt);
      dpr_pkg::REG_WIDTH:  prdata = 32'(cfg_r.width);
      dpr_pkg::REG_HEIGHT: prdata = 32'(cfg_r.height);
      default:             prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

/* rtl/dpr_decode.sv */
module dpr_decode #(
  parameter int unsigned MAX_DIM = dpr_pkg::MAX_DIM_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic [7:0]    data_byte,
  input  dpr_pkg::cfg_t cfg,
  output logic          emit,
  output dpr_pkg::pix_t pix
);

  localparam int unsigned CW = $clog2(MAX_DIM);
  localparam int unsigned DW = $clog2(MAX_DIM + 1);

  logic [1:0]    phase_r,   phase_nxt;
  logic [23:0]   partial_r, partial_nxt;
  logic [CW-1:0] col_r,     col_nxt;
  logic [CW-1:0] row_r,     row_nxt;
  logic [1:0]    pad_r,     pad_nxt;
  logic          in_pad_r,  in_pad_nxt;

  logic [DW-1:0] w, h;
  logic [DW-1:0] col_inc, row_inc;
  logic          col_end, row_end;
  logic [CW-1:0] row_adv;
  logic [1:0]    last_phase;
  logic [15:0]   word16;
  logic [7:0]    r, g, b;
  logic [1:0]    pad_len;
  logic [31:0]   col_ext, row_diff;

  // zero reads as 1, anything above the limit as the limit
  always_comb begin
    if (cfg.width == '0) w = DW'(1);
    else if (32'(cfg.width) > 32'(MAX_DIM)) w = DW'(MAX_DIM);
    else w = DW'(cfg.width);
    if (cfg.height == '0) h = DW'(1);
    else if (32'(cfg.height) > 32'(MAX_DIM)) h = DW'(MAX_DIM);
    else h = DW'(cfg.height);
  end

  assign col_inc = DW'(col_r) + DW'(1);
  assign row_inc = DW'(row_r) + DW'(1);
  assign col_end = col_inc >= w;
  assign row_end = row_inc >= h;
  assign row_adv = row_end ? '0 : CW'(row_inc);

  assign last_phase = 2'(cfg.fmt) + 2'd1;

  assign word16 = {data_byte, partial_r[7:0]};

  always_comb begin
    case (cfg.fmt)
      dpr_pkg::FMT_RGB555: begin
        r = {5'((word16 >> 10) & dpr_pkg::CHAN5_MASK), 3'b000};
        g = {5'((word16 >> 5) & dpr_pkg::CHAN5_MASK), 3'b000};
        b = {5'(word16 & dpr_pkg::CHAN5_MASK), 3'b000};
      end
      dpr_pkg::FMT_BGR24: begin
        b = partial_r[7:0];
        g = partial_r[15:8];
        r = data_byte;
      end
      default: begin
        b = partial_r[7:0];
        g = partial_r[15:8];
        r = partial_r[23:16];
      end
    endcase
  end

  always_comb begin
    case (cfg.fmt)
      dpr_pkg::FMT_RGB555: pad_len = w[0] ? 2'd2 : 2'd0;
      dpr_pkg::FMT_BGR24:  pad_len = w[1:0];
      default:             pad_len = 2'd0;
    endcase
  end

  assign col_ext  = 32'(col_r);
  assign row_diff = 32'(h) - 32'(row_r) - 32'd1;

  assign pix.pixel_x    = col_ext[11:0];
  assign pix.pixel_row  = row_diff[11:0];
  assign pix.red        = r;
  assign pix.green      = g;
  assign pix.blue       = b;
  assign pix.last_pixel = col_end && row_end;

  always_comb begin
    phase_nxt   = phase_r;
    partial_nxt = partial_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    pad_nxt     = pad_r;
    in_pad_nxt  = in_pad_r;
    emit        = 1'b0;
    if (step) begin
      if (in_pad_r) begin
        if (pad_r <= 2'd1) begin
          pad_nxt    = 2'd0;
          in_pad_nxt = 1'b0;
          row_nxt    = row_adv;
        end else begin
          pad_nxt = pad_r - 2'd1;
        end
      end else if (cfg.fmt == dpr_pkg::FMT_NONE) begin
        // byte dropped, state kept
      end else if (phase_r < last_phase) begin
        case (phase_r)
          2'd0:    partial_nxt[7:0]   = data_byte;
          2'd1:    partial_nxt[15:8]  = data_byte;
          2'd2:    partial_nxt[23:16] = data_byte;
          default: ;
        endcase
        phase_nxt = phase_r + 2'd1;
      end else begin
        emit        = 1'b1;
        phase_nxt   = 2'd0;
        partial_nxt = '0;
        if (col_end) begin
          col_nxt = '0;
          if (pad_len != 2'd0) begin
            in_pad_nxt = 1'b1;
            pad_nxt    = pad_len;
          end else begin
            row_nxt = row_adv;
          end
        end else begin
          col_nxt = CW'(col_inc);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= '0;
      partial_r <= '0;
      col_r     <= '0;
      row_r     <= '0;
      pad_r     <= '0;
      in_pad_r  <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      partial_r <= partial_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      pad_r     <= pad_nxt;
      in_pad_r  <= in_pad_nxt;
    end
  end

endmodule

/* rtl/dib_pixel_row_decoder_unit.sv */
// channel | ports                        | direction
// input   | in_valid, in_stall, in_*     | one raw pixel-array byte per item
// result  | out_valid, out_stall, out_*  | one decoded pixel per item
// config  | psel/penable/pwrite/paddr    | format 0x0, width 0x4, height 0x8
//
// one byte per cycle sustained while the result is not stalled: input register,
// then combinational decode and counter update into the result register
// synchronous active-low reset clears counters, phase and both valid flags
// a stalled result holds the result register; the input register then fills
// and in_stall rises only while a byte waits behind the held result
module dib_pixel_row_decoder_unit #(
  parameter int unsigned MAX_DIM = dpr_pkg::MAX_DIM_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_data_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [11:0]                 out_pixel_x,
  output logic [11:0]                 out_pixel_row,
  output logic [7:0]                  out_red,
  output logic [7:0]                  out_green,
  output logic [7:0]                  out_blue,
  output logic                        out_last_pixel,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dpr_pkg::PADDR_W-1:0] paddr,
  input  logic [dpr_pkg::PDATA_W-1:0] pwdata,
  output logic [dpr_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  dpr_pkg::cfg_t cfg;
  dpr_pkg::pix_t pix;
  dpr_pkg::pix_t res_r;
  logic          emit;
  logic          hold_valid_r, hold_valid_nxt;
  logic [7:0]    hold_byte_r;
  logic          out_valid_r, out_valid_nxt;
  logic          step;

  dpr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // the held byte moves on whenever the result register is free or drains
  assign step     = hold_valid_r && !(out_valid_r && out_stall);
  assign in_stall = hold_valid_r && !step;

  dpr_decode #(
    .MAX_DIM (MAX_DIM)
  ) u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (hold_byte_r),
    .cfg       (cfg),
    .emit      (emit),
    .pix       (pix)
  );

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (!in_stall) hold_valid_nxt = in_valid;
    if (step) out_valid_nxt = emit;
    else if (out_stall) out_valid_nxt = out_valid_r;
    else out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) hold_byte_r <= in_data_byte;
    if (step && emit) res_r <= pix;
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_x    = res_r.pixel_x;
  assign out_pixel_row  = res_r.pixel_row;
  assign out_red        = res_r.red;
  assign out_green      = res_r.green;
  assign out_blue       = res_r.blue;
  assign out_last_pixel = res_r.last_pixel;

endmodule

/* rtl/dpr_checker.sv */
`include "assert_macros.svh"

module dpr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [11:0] out_pixel_x,
  input logic [11:0] out_pixel_row,
  input logic [7:0]  out_red,
  input logic [7:0]  out_green,
  input logic [7:0]  out_blue,
  input logic        out_last_pixel
);

  logic [48:0] out_bus;

  assign out_bus = {out_pixel_x, out_pixel_row, out_red, out_green, out_blue, out_last_pixel};

  // a held result keeps its place
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

  `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_bus))

  // backpressure on the input only comes from a stalled result
  `ASSERT_IMPL(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

  // nothing leaves in the cycle right after reset
  `ASSERT_IMPL(a_reset_quiet, clk, rst_n, !$past(rst_n), !out_valid)

endmodule

bind dib_pixel_row_decoder_unit dpr_checker u_dpr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_pixel_x    (out_pixel_x),
  .out_pixel_row  (out_pixel_row),
  .out_red        (out_red),
  .out_green      (out_green),
  .out_blue       (out_blue),
  .out_last_pixel (out_last_pixel)
);

/* tb/pixel_decode_checker.sv */
module pixel_decode_checker
  import dpr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [7:0]          in_data_byte,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [11:0]         out_pixel_x,
  input  logic [11:0]         out_pixel_row,
  input  logic [7:0]          out_red,
  input  logic [7:0]          out_green,
  input  logic [7:0]          out_blue,
  input  logic                out_last_pixel,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output int                  mismatches,
  output int                  pending,
  output int                  bytes_seen,
  output int                  pixels_seen,
  output int                  images_seen,
  output int                  writes_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copies
  fmt_t             fmt;
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;

  // decoder state
  logic [1:0]  phase;
  logic [23:0] acc;
  int unsigned col;
  int unsigned row;
  int unsigned pad_left;
  bit          pad_busy;

  pix_t pixels_due[$];
  int   err_cnt;
  int   byte_cnt;
  int   pix_cnt;
  int   img_cnt;
  int   wr_cnt;

  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
    return v;
  endfunction

  task automatic next_row();
    if (row + 1 >= clamp_dim(height_reg)) row = 0;
    else row = row + 1;
  endtask

  task automatic decode_byte(input logic [7:0] b);
    int unsigned w;
    int unsigned h;
    int unsigned pad;
    logic [15:0] word;
    pix_t        p;
    if (pad_busy) begin
      if (pad_left <= 1) begin
        pad_left = 0;
        pad_busy = 0;
        next_row();
      end else begin
        pad_left = pad_left - 1;
      end
      return;
    end
    if (fmt == FMT_NONE) return;
    // still gathering: the byte that reaches the format's last byte closes the pixel
    if (phase < (int'(fmt) + 1)) begin
      if (phase < 3) acc[8*phase +: 8] = b;
      phase = phase + 2'd1;
      return;
    end
    case (fmt)
      FMT_RGB555: begin
        word    = {b, acc[7:0]};
        p.red   = {word[14:10], 3'b000};
        p.green = {word[9:5], 3'b000};
        p.blue  = {word[4:0], 3'b000};
      end
      FMT_BGR24: begin
        p.blue  = acc[7:0];
        p.green = acc[15:8];
        p.red   = b;
      end
      default: begin
        p.blue  = acc[7:0];
        p.green = acc[15:8];
        p.red   = acc[23:16];
      end
    endcase
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    p.pixel_x    = col[11:0];
    p.pixel_row  = 12'(h - row - 1);
    p.last_pixel = (col + 1 >= w) && (row + 1 >= h);
    pixels_due.push_back(p);
    phase = '0;
    acc   = '0;
    if (col + 1 >= w) begin
      col = 0;
      case (fmt)
        FMT_RGB555: pad = w[0] ? 2 : 0;
        FMT_BGR24:  pad = w & 3;
        default:    pad = 0;
      endcase
      if (pad != 0) begin
        pad_busy = 1;
        pad_left = pad;
      end else begin
        next_row();
      end
    end else begin
      col = col + 1;
    end
  endtask

  always @(posedge clk) begin
    pix_t want;
    pix_t got;
    if (!rst_n) begin
      fmt        = FMT_RESET;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      phase      = '0;
      acc        = '0;
      col        = 0;
      row        = 0;
      pad_left   = 0;
      pad_busy   = 0;
      pixels_due.delete();
      err_cnt    = 0;
      byte_cnt   = 0;
      pix_cnt    = 0;
      img_cnt    = 0;
      wr_cnt     = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_pixel_x, out_pixel_row, out_red, out_green, out_blue, out_last_pixel};
        pix_cnt++;
        if (out_last_pixel) img_cnt++;
        if (pixels_due.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: pixel with none expected: x=%0d row=%0d rgb=%02h%02h%02h last=%0b",
                     $time, got.pixel_x, got.pixel_row, got.red, got.green, got.blue,
                     got.last_pixel);
        end else begin
          want = pixels_due.pop_front();
          if (got.pixel_x !== want.pixel_x || got.pixel_row !== want.pixel_row ||
              got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue || got.last_pixel !== want.last_pixel) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("%0t: pixel mismatch", $time);
              $display("  expected x=%0d row=%0d rgb=%02h%02h%02h last=%0b",
                       want.pixel_x, want.pixel_row, want.red, want.green, want.blue,
                       want.last_pixel);
              $display("  actual   x=%0d row=%0d rgb=%02h%02h%02h last=%0b",
                       got.pixel_x, got.pixel_row, got.red, got.green, got.blue,
                       got.last_pixel);
            end
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        wr_cnt++;
        case (reg_idx_t'(paddr[3:2]))
          REG_FORMAT: fmt        = fmt_t'(pwdata[1:0]);
          REG_WIDTH:  width_reg  = pwdata[DIM_W-1:0];
          REG_HEIGHT: height_reg = pwdata[DIM_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        byte_cnt++;
        decode_byte(in_data_byte);
      end
    end
    mismatches  <= err_cnt;
    pending     <= pixels_due.size();
    bytes_seen  <= byte_cnt;
    pixels_seen <= pix_cnt;
    images_seen <= img_cnt;
    writes_seen <= wr_cnt;
  end

endmodule

/* tb/dib_pixel_row_decoder_unit_tb.sv */
module dib_pixel_row_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dpr_pkg::*;

  localparam int RANDOM_BYTES = 650;
  localparam int DRAIN_CYCLES = 6;
  localparam int LONG_HOLD    = 200;
  localparam int HOLD_PHASE   = 3;
  localparam int CYCLE_LIMIT  = 400000;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         in_data_byte;
  logic               out_valid;
  logic               out_stall;
  logic [11:0]        out_pixel_x;
  logic [11:0]        out_pixel_row;
  logic [7:0]         out_red;
  logic [7:0]         out_green;
  logic [7:0]         out_blue;
  logic               out_last_pixel;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int mismatches;
  int pending;
  int bytes_seen;
  int pixels_seen;
  int images_seen;
  int writes_seen;

  // settings as last written, used to size whole images
  fmt_t             cur_fmt = FMT_RESET;
  logic [DIM_W-1:0] cur_w   = WIDTH_RESET;
  logic [DIM_W-1:0] cur_h   = HEIGHT_RESET;

  bit tx_fast = 1'b0;
  bit rx_fast = 1'b0;
  bit rx_hold = 1'b0;
  bit hold_go = 1'b0;
  int rand_bytes = 0;
  int cycle_cnt;

  dib_pixel_row_decoder_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel_x   (out_pixel_x),
    .out_pixel_row (out_pixel_row),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_last_pixel(out_last_pixel),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  pixel_decode_checker pixel_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel_x   (out_pixel_x),
    .out_pixel_row (out_pixel_row),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_last_pixel(out_last_pixel),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .mismatches    (mismatches),
    .pending       (pending),
    .bytes_seen    (bytes_seen),
    .pixels_seen   (pixels_seen),
    .images_seen   (images_seen),
    .writes_seen   (writes_seen)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int draw_wait(input bit fast);
    return fast ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim(input int unsigned max_small);
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 6))
          0:       return 13'd0;
          1:       return 13'd1;
          2:       return 13'd2;
          3:       return 13'd4095;
          4:       return 13'd4096;
          5:       return 13'd4097;
          default: return 13'd8191;
        endcase
      end
      1:       return 13'($urandom_range(0, 8191));
      default: return 13'($urandom_range(1, max_small));
    endcase
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [DIM_W-1:0] v);
    logic [31:0] word;
    // unused upper bits carry noise
    word = $urandom;
    word[DIM_W-1:0] = v;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FORMAT: cur_fmt = fmt_t'(v[1:0]);
      REG_WIDTH:  cur_w   = v;
      REG_HEIGHT: cur_h   = v;
      default: ;
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_wait(tx_fast || rx_hold);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  // block is idle once every pixel is back and pad or partial bytes have settled
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) stall_left = draw_wait(rx_fast);
      else if (stall_left > 0) stall_left--;
      out_stall <= rx_hold || (stall_left > 0);
    end
  end

  // long receiver hold so the block fills and pushes back on its input
  initial begin : long_hold
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d pixels outstanding", cycle_cnt, pending);
    $display("dib_pixel_row_decoder_unit_tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    int          phase_no;
    int          nbytes;
    int unsigned w;
    int unsigned h;
    int unsigned row_bytes;
    logic [7:0]  rb;
    in_valid     <= 1'b0;
    in_data_byte <= 8'h00;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    rst_n        <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: a 1x1 24 bpp image and its pad byte
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h80);
    send_byte(8'h5a);
    wait_idle();
    // 16 bpp, odd width pads two bytes; the top bit of the word is ignored
    write_reg(REG_FORMAT, 13'(FMT_RGB555));
    write_reg(REG_HEIGHT, 13'd2);
    send_byte(8'hff);
    send_byte(8'hff);
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'h33);
    send_byte(8'h44);
    wait_idle();
    // 32 bpp drops the fourth byte
    write_reg(REG_FORMAT, 13'(FMT_BGRX32));
    write_reg(REG_WIDTH, 13'd2);
    write_reg(REG_HEIGHT, 13'd1);
    send_byte(8'h01);
    send_byte(8'h02);
    send_byte(8'h03);
    send_byte(8'hff);
    send_byte(8'hfe);
    send_byte(8'hfd);
    send_byte(8'hfc);
    send_byte(8'h00);
    wait_idle();
    // unsupported depth swallows bytes
    write_reg(REG_FORMAT, 13'(FMT_NONE));
    send_byte(8'haa);
    send_byte(8'h55);
    wait_idle();
    // zero width reads as one, oversize height as the maximum
    write_reg(REG_WIDTH, 13'd0);
    write_reg(REG_HEIGHT, 13'd8191);
    write_reg(REG_FORMAT, 13'(FMT_BGR24));
    send_byte(8'h7f);
    send_byte(8'h80);
    send_byte(8'hc3);

    phase_no = 0;
    while (rand_bytes < RANDOM_BYTES) begin
      wait_idle();
      tx_fast = ($urandom_range(0, 3) == 0);
      rx_fast <= ($urandom_range(0, 3) == 0);
      if (phase_no == HOLD_PHASE) begin
        write_reg(REG_FORMAT, 13'(FMT_BGR24));
        write_reg(REG_WIDTH, 13'd5);
        tx_fast = 1'b1;
        hold_go = 1'b1;
        nbytes  = 90;
      end else begin
        if (phase_no == 0 || $urandom_range(0, 2) != 0)
          write_reg(REG_FORMAT, ($urandom_range(0, 9) == 0) ? 13'(FMT_NONE)
                                                             : 13'($urandom_range(0, 2)));
        if (phase_no == 0 || $urandom_range(0, 2) != 0)
          write_reg(REG_WIDTH, pick_dim(9));
        if (phase_no == 0 || $urandom_range(0, 2) != 0)
          write_reg(REG_HEIGHT, pick_dim(6));
        w = (cur_w == 0) ? 1 : (cur_w > MAX_DIM_DEF) ? MAX_DIM_DEF : cur_w;
        h = (cur_h == 0) ? 1 : (cur_h > MAX_DIM_DEF) ? MAX_DIM_DEF : cur_h;
        case (cur_fmt)
          FMT_RGB555: row_bytes = 2 * w + (w[0] ? 2 : 0);
          FMT_BGR24:  row_bytes = 3 * w + (w & 3);
          default:    row_bytes = 4 * w;
        endcase
        // often a whole image so the counters wrap, else a random slice
        if (cur_fmt != FMT_NONE && row_bytes * h <= 200 && $urandom_range(0, 1) == 1)
          nbytes = row_bytes * h;
        else
          nbytes = $urandom_range(4, 60);
      end
      for (int i = 0; i < nbytes; i++) begin
        if ($urandom_range(0, 7) == 0) rb = ($urandom_range(0, 1) == 1) ? 8'hff : 8'h00;
        else rb = 8'($urandom);
        send_byte(rb);
      end
      if (cur_fmt != FMT_NONE) rand_bytes += nbytes;
      phase_no++;
    end

    wait_idle();
    $display("covered %0d bytes in %0d settings phases with %0d register writes",
             bytes_seen, phase_no, writes_seen);
    $display("checked %0d pixels across %0d image ends", pixels_seen, images_seen);
    if (pending != 0) $display("%0d expected pixels never arrived", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("dib_pixel_row_decoder_unit_tb: PASS");
    end else begin
      $display("dib_pixel_row_decoder_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
